// File: hw/rtl/brace_fold_region_finder_core_assert.svh
// assertion macros shared by the brace fold region finder modules
`ifndef BRACE_FOLD_REGION_FINDER_CORE_ASSERT_SVH
`define BRACE_FOLD_REGION_FINDER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BFFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bffr_pkg.sv
// package with command codes, character codes and stack op types
`timescale 1ns / 1ps

package bffr_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_CHAR       = 2'd0,
    CMD_EOL        = 2'd1,
    CMD_NEW_BUFFER = 2'd2
  } cmd_t;

  // stack operation issued by the front end
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_kind_t;

  // special characters
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;

  // width of the fold line outputs
  localparam int OUT_LINE_BITS = 16;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// File: hw/rtl/bffr_front.sv
// front end: quote tracking, line counting and stack op issue
`timescale 1ns / 1ps
`include "brace_fold_region_finder_core_assert.svh"

module bffr_front #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 16,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic [7:0]             character,
  output logic                   op_valid,
  output bffr_pkg::op_kind_t     op_kind,
  output logic [AW-1:0]          op_addr,
  output logic [LINE_BITS-1:0]   op_line,
  input  logic                   op_stall
);

  localparam int FW = $clog2(STACK_DEPTH + 1);

  logic                 in_single_quote;
  logic                 in_double_quote;
  logic                 escape_pending;
  logic [LINE_BITS-1:0] current_line;
  logic [FW-1:0]        fill;

  logic          accept;
  logic          is_char;
  logic          outside;
  logic          do_push;
  logic          do_pop;
  logic [FW-1:0] fill_m1;

  // item handshake: stall only while the op queue is full
  assign in_stall = op_stall;
  assign accept   = in_valid && !op_stall;

  // classify the character against quote state before it
  assign is_char = (bffr_pkg::cmd_t'(command) == bffr_pkg::CMD_CHAR);
  assign outside = !in_single_quote && !in_double_quote;
  assign do_push = is_char && outside && (character == bffr_pkg::CH_LBRACE)
                   && (fill < FW'(STACK_DEPTH));
  assign do_pop  = is_char && outside && (character == bffr_pkg::CH_RBRACE)
                   && (fill != '0);
  assign fill_m1 = fill - FW'(1);

  // stack op toward the back end
  assign op_valid = accept && (do_push || do_pop);
  assign op_kind  = do_push ? bffr_pkg::OP_PUSH : bffr_pkg::OP_POP;
  assign op_addr  = do_push ? fill[AW-1:0] : fill_m1[AW-1:0];
  assign op_line  = current_line;

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_single_quote <= 1'b0;
      in_double_quote <= 1'b0;
      escape_pending  <= 1'b0;
      current_line    <= '0;
      fill            <= '0;
    end else if (accept) begin
      case (bffr_pkg::cmd_t'(command))
        bffr_pkg::CMD_NEW_BUFFER: begin
          in_single_quote <= 1'b0;
          in_double_quote <= 1'b0;
          escape_pending  <= 1'b0;
          current_line    <= '0;
          fill            <= '0;
        end
        bffr_pkg::CMD_EOL: begin
          in_single_quote <= 1'b0;
          in_double_quote <= 1'b0;
          escape_pending  <= 1'b0;
          if (current_line != '1) begin
            current_line <= current_line + LINE_BITS'(1);
          end
        end
        bffr_pkg::CMD_CHAR: begin
          if (do_push) begin
            fill <= fill + FW'(1);
          end else if (do_pop) begin
            fill <= fill_m1;
          end
          // quote and escape update
          if (escape_pending) begin
            escape_pending <= 1'b0;
          end else if (character == bffr_pkg::CH_BACKSLASH) begin
            escape_pending <= 1'b1;
          end else if (character == bffr_pkg::CH_SQUOTE && !in_double_quote) begin
            in_single_quote <= !in_single_quote;
          end else if (character == bffr_pkg::CH_DQUOTE && !in_single_quote) begin
            in_double_quote <= !in_double_quote;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // checks
  `BFFR_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill <= FW'(STACK_DEPTH), "stack fill beyond depth")
  `BFFR_ASSERT_NEXT(a_new_buffer_clear, clk, rst, accept && (bffr_pkg::cmd_t'(command) == bffr_pkg::CMD_NEW_BUFFER), (fill == '0) && (current_line == '0) && !escape_pending, "new buffer did not clear state")

endmodule

// File: hw/rtl/bffr_queue.sv
// small register queue between front and back
`timescale 1ns / 1ps
`include "brace_fold_region_finder_core_assert.svh"

module bffr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // checks
  `BFFR_ASSERT_SAME(a_no_overflow, clk, rst, full, !push, "push into full queue")
  `BFFR_ASSERT_SAME(a_no_underflow, clk, rst, !valid, !pop, "pop from empty queue")

endmodule

// File: hw/rtl/bffr_back.sv
// back end: stack memory, pop compare and output register
`timescale 1ns / 1ps
`include "brace_fold_region_finder_core_assert.svh"

module bffr_back #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 16,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             op_valid,
  input  bffr_pkg::op_kind_t               op_kind,
  input  logic [AW-1:0]                    op_addr,
  input  logic [LINE_BITS-1:0]             op_line,
  output logic                             op_take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bffr_pkg::OUT_LINE_BITS-1:0] fold_start_line,
  output logic [bffr_pkg::OUT_LINE_BITS-1:0] fold_end_line
);

  localparam int OW = bffr_pkg::OUT_LINE_BITS;

  logic [LINE_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [LINE_BITS-1:0] rd_data;
  logic                 s1_valid;
  logic [LINE_BITS-1:0] s1_end;

  logic                    out_free;
  logic                    s1_free;
  logic                    is_push;
  logic                    issue_pop;
  logic [LINE_BITS+OW-1:0] start_ext;
  logic [LINE_BITS+OW-1:0] end_ext;

  // flow control: pushes always issue, pops need room in the read stage
  assign out_free  = !out_valid || !out_stall;
  assign s1_free   = !s1_valid || out_free;
  assign is_push   = (op_kind == bffr_pkg::OP_PUSH);
  assign op_take   = op_valid && (is_push || s1_free);
  assign issue_pop = op_take && !is_push;

  // stack memory, one access per cycle
  always_ff @(posedge clk) begin
    if (op_take && is_push) begin
      stack_mem[op_addr] <= op_line;
    end
    if (issue_pop) begin
      rd_data <= stack_mem[op_addr];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_pop) begin
      s1_end <= op_line;
    end
  end

  // line numbers cut or widened to the output width
  assign start_ext = {{OW{1'b0}}, rd_data};
  assign end_ext   = {{OW{1'b0}}, s1_end};

  // output register, filled only for multi-line pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && (rd_data < s1_end);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      fold_start_line <= start_ext[OW-1:0];
      fold_end_line   <= end_ext[OW-1:0];
    end
  end

  // checks
  `BFFR_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_free, s1_valid && $stable(s1_end), "read stage lost while output stalled")

endmodule

// File: hw/rtl/brace_fold_region_finder_core.sv
// Brace fold region finder: top level tying front end, op queue and back end.
// Path: an item that closes a multi-line brace pair goes through a queue slot (written
// at acceptance), the stack read and the output register; output stall can hold it.
// Throughput: one item per cycle while the op queue is not full; the stack memory
// takes one push or pop per cycle.
// Reset: synchronous rst clears quote, line, fill and queue state; the stack memory
// is not cleared and needs no clearing pass, since only written entries are read.
`timescale 1ns / 1ps

module brace_fold_region_finder_core #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] fold_start_line,
  output logic [15:0] fold_end_line
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int QW = 1 + AW + LINE_BITS;

  logic                 f_op_valid;
  bffr_pkg::op_kind_t   f_op_kind;
  logic [AW-1:0]        f_op_addr;
  logic [LINE_BITS-1:0] f_op_line;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_take;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;

  // front end
  bffr_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .character (character),
    .op_valid  (f_op_valid),
    .op_kind   (f_op_kind),
    .op_addr   (f_op_addr),
    .op_line   (f_op_line),
    .op_stall  (q_full)
  );

  // op queue
  assign q_wdata = {f_op_kind, f_op_addr, f_op_line};

  bffr_queue #(
    .WIDTH (QW),
    .DEPTH (bffr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_op_valid),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_take),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  // back end
  bffr_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .AW          (AW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .op_valid        (q_valid),
    .op_kind         (bffr_pkg::op_kind_t'(q_rdata[QW-1])),
    .op_addr         (q_rdata[AW+LINE_BITS-1:LINE_BITS]),
    .op_line         (q_rdata[LINE_BITS-1:0]),
    .op_take         (q_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .fold_start_line (fold_start_line),
    .fold_end_line   (fold_end_line)
  );

endmodule

// File: dv/brace_fold_region_finder_core_test.sv
// self-checking testbench for the brace fold region finder core
`timescale 1ns / 1ps

module brace_fold_region_finder_core_test;

  localparam int STACK_DEPTH = 64;
  localparam int LINE_BITS = 16;
  localparam logic [LINE_BITS-1:0] LINE_LAST = '1;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [15:0] first_line;
    logic [15:0] end_line;
  } fold_t;

  // tracks quote, line and open-brace state and the folds still owed
  class fold_scoreboard;
    bit in_sq;
    bit in_dq;
    bit esc_pend;
    logic [LINE_BITS-1:0] line_num;
    logic [LINE_BITS-1:0] open_lines [STACK_DEPTH];
    int unsigned depth;
    fold_t folds_due [$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      in_sq = 1'b0;
      in_dq = 1'b0;
      esc_pend = 1'b0;
      line_num = '0;
      depth = 0;
    endfunction

    // accepted input item
    function void note_item(logic [1:0] cmd, logic [7:0] ch);
      fold_t f;
      case (cmd)
        bffr_pkg::CMD_NEW_BUFFER: begin
          clear_state();
        end
        bffr_pkg::CMD_EOL: begin
          in_sq = 1'b0;
          in_dq = 1'b0;
          esc_pend = 1'b0;
          if (line_num != LINE_LAST) line_num++;
        end
        bffr_pkg::CMD_CHAR: begin
          // braces count only outside quotes, judged before this byte
          if (!in_sq && !in_dq) begin
            if (ch == bffr_pkg::CH_LBRACE) begin
              if (depth < STACK_DEPTH) begin
                open_lines[depth] = line_num;
                depth++;
              end
            end else if (ch == bffr_pkg::CH_RBRACE && depth != 0) begin
              depth--;
              if (open_lines[depth] < line_num) begin
                f.first_line = 16'(open_lines[depth]);
                f.end_line = 16'(line_num);
                folds_due.push_back(f);
              end
            end
          end
          // quote and escape tracking
          if (esc_pend) esc_pend = 1'b0;
          else if (ch == bffr_pkg::CH_BACKSLASH) esc_pend = 1'b1;
          else if (ch == bffr_pkg::CH_SQUOTE && !in_dq) in_sq = !in_sq;
          else if (ch == bffr_pkg::CH_DQUOTE && !in_sq) in_dq = !in_dq;
        end
        default: begin
        end
      endcase
    endfunction

    // accepted result against the oldest fold owed
    function void check_fold(logic [15:0] s, logic [15:0] e);
      fold_t f;
      if (folds_due.size() == 0) begin
        $display("%0t: unexpected fold, expected none, actual start %0d end %0d", $time, s, e);
        errors++;
        return;
      end
      f = folds_due.pop_front();
      if (s !== f.first_line) begin
        $display("%0t: fold_start_line mismatch, expected %0d actual %0d",
                 $time, f.first_line, s);
        errors++;
      end
      if (e !== f.end_line) begin
        $display("%0t: fold_end_line mismatch, expected %0d actual %0d",
                 $time, f.end_line, e);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] command;
  logic [7:0] character;
  logic out_valid;
  logic out_stall;
  logic [15:0] fold_start_line;
  logic [15:0] fold_end_line;

  fold_scoreboard sb = new();
  bit idle_on;
  int stall_left;
  int unsigned item_count;

  brace_fold_region_finder_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_BITS(LINE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .character(character),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fold_start_line(fold_start_line),
    .fold_end_line(fold_end_line)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len();
    end
  end

  // acceptance monitor on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(command, character);
    if (!rst && out_valid && !out_stall) sb.check_fold(fold_start_line, fold_end_line);
  end

  // one item, with an optional idle gap ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    character <= ch;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(bffr_pkg::CMD_CHAR, s[i]);
  endtask

  task automatic send_eol();
    send_item(bffr_pkg::CMD_EOL, 8'h00);
  endtask

  // hold the sender until every fold owed has come out
  task automatic drain_folds();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.folds_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // weighted text item for the random part
  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) send_item(bffr_pkg::CMD_CHAR, bffr_pkg::CH_LBRACE);
    else if (r < 37) send_item(bffr_pkg::CMD_CHAR, bffr_pkg::CH_RBRACE);
    else if (r < 44) send_item(bffr_pkg::CMD_CHAR, bffr_pkg::CH_DQUOTE);
    else if (r < 51) send_item(bffr_pkg::CMD_CHAR, bffr_pkg::CH_SQUOTE);
    else if (r < 56) send_item(bffr_pkg::CMD_CHAR, bffr_pkg::CH_BACKSLASH);
    else if (r < 72) send_item(bffr_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
    else if (r < 73) send_item(bffr_pkg::CMD_NEW_BUFFER, 8'($urandom_range(0, 255)));
    else if (r < 74) begin
      send_item(CMD_IGNORED, 8'($urandom_range(0, 255)));
      return;
    end else send_item(bffr_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
    item_count++;
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = bffr_pkg::CMD_CHAR;
    character = 8'h00;
    idle_on = 1'b1;
    item_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fold, empty pop, same-line pair, quotes, escapes, extremes
    send_text("{");
    send_eol();
    send_text("}}{}");
    send_text("\"{\"");
    send_text("\\\"{");
    send_text("\\{'\"{'");
    send_eol();
    send_item(bffr_pkg::CMD_CHAR, 8'h00);
    send_item(bffr_pkg::CMD_CHAR, 8'hFF);
    send_item(CMD_IGNORED, 8'hFF);
    send_text("'");
    send_eol();
    send_text("}}}");
    send_item(bffr_pkg::CMD_NEW_BUFFER, 8'h00);
    send_text("}");
    drain_folds();

    // stack overflow: more opens than the stack holds, then unwind past empty
    for (int i = 0; i < STACK_DEPTH + 6; i++) begin
      send_text("{");
      send_eol();
    end
    for (int i = 0; i < STACK_DEPTH + 6; i++) send_text("}");
    send_item(bffr_pkg::CMD_NEW_BUFFER, 8'h00);
    drain_folds();

    // random text
    while (item_count < RANDOM_ITEMS) begin
      send_random_item();
      if (item_count % 250 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (item_count == RANDOM_ITEMS / 2) drain_folds();
    end

    // wait for the last folds, then watch for stray results
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.folds_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bffr_pkg.sv
hw/rtl/bffr_front.sv
hw/rtl/bffr_queue.sv
hw/rtl/bffr_back.sv
hw/rtl/brace_fold_region_finder_core.sv
dv/brace_fold_region_finder_core_test.sv
